[sv/mdio_rd_pkg.sv]
package mdio_rd_pkg;

	// Fixed field and state widths
	localparam int HALF_W   = 8;
	localparam int BIT_W    = 7;
	localparam int CMD_BITS = 16;
	localparam int SAMPLE_W = 19;
	localparam int DATA_W   = 16;
	localparam int ADDR_W   = 5;

	// Two further preamble ones, start-of-frame and read opcode bits sent ahead of the addresses
	localparam logic [5:0] OP_PREFIX = 6'b110110;

	// Command codes of an input item
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] phy_address;
		logic [ADDR_W-1:0] reg_address;
		logic              mdio_in;
	} in_item_t;

	typedef struct packed {
		logic              mdc;
		logic              mdio_out;
		logic              mdio_drive;
		logic              busy_res;
		logic              done_res;
		logic [DATA_W-1:0] read_data;
	} out_item_t;

endpackage

[sv/mdio_management_read_master_top.sv]
// Management-bus read master (clause 22 read frames).
// Input channel (in_valid/in_stall/in_data) carries items that are either a
// start request with PHY and register address, or a tick that stands for one
// half period of the management clock. Every accepted item yields exactly one
// result item on the output channel (out_valid/out_stall/out_data) holding the
// pin levels for that half (mdc, mdio_out, mdio_drive), the busy flag, a done
// pulse and the data of the last completed read.
// The result of an item is in the output register on the clock after acceptance.
// Throughput is one item per cycle while out_stall does not hold the output; the
// frame counter and shift registers update in the same cycle the item is taken.
// A full frame needs 2*(PREAMBLE_BITS+16+READ_CLOCKS) ticks after the start.
// Starts that arrive during a frame are ignored and repeat the last half.
// When the receiver stalls, the output register holds its item and the input
// channel stalls too; a new item enters in the cycle the held one is taken.
// Reset (arst_n low) returns the block to idle with read_data cleared and no
// result pending.
module mdio_management_read_master_top
	import mdio_rd_pkg::*;
#(
	parameter int PREAMBLE_BITS = 33,
	parameter int READ_CLOCKS   = 19
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam logic [BIT_W-1:0] PRE_END = BIT_W'(PREAMBLE_BITS);
	localparam logic [BIT_W-1:0] CMD_END = BIT_W'(PREAMBLE_BITS + CMD_BITS);
	localparam logic [HALF_W-1:0] TOTAL_HALVES =
		HALF_W'(2 * (PREAMBLE_BITS + CMD_BITS + READ_CLOCKS));

	logic [HALF_W-1:0]   count_q;
	logic [CMD_BITS-1:0] cmd_word_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                busy_q;
	logic [DATA_W-1:0]   result_q;

	logic                in_accept;
	logic [HALF_W-1:0]   half_sel;
	logic [BIT_W-1:0]    bit_idx;
	logic [BIT_W-1:0]    cmd_off;
	logic                pin_clk;
	logic                pin_dout;
	logic                pin_drv;
	logic                show_pins;
	logic [HALF_W-1:0]   half_inc;
	logic [HALF_W-1:0]   count_nxt;
	logic [CMD_BITS-1:0] cmd_word_nxt;
	logic [SAMPLE_W-1:0] sample_nxt;
	logic                busy_nxt;
	logic [DATA_W-1:0]   result_nxt;
	logic                done_nxt;
	out_item_t           res_nxt;

	// One-entry output register; input moves whenever it can drain
	assign in_stall  = out_valid & out_stall;
	assign in_accept = in_valid & ~in_stall;

	// Pin levels for the selected half of the frame
	always_comb begin
		half_sel = (in_data.command == CMD_START) ? count_q - HALF_W'(1) : count_q;
		bit_idx  = half_sel[HALF_W-1:1];
		cmd_off  = bit_idx - PRE_END;
		pin_clk  = half_sel[0];
		if (bit_idx < PRE_END) begin
			pin_dout = 1'b1;
			pin_drv  = 1'b1;
		end else if (bit_idx < CMD_END) begin
			pin_dout = cmd_word_q[~cmd_off[3:0]];
			pin_drv  = 1'b1;
		end else begin
			pin_dout = 1'b0;
			pin_drv  = 1'b0;
		end
	end

	// Frame sequencing for one item
	always_comb begin
		count_nxt    = count_q;
		cmd_word_nxt = cmd_word_q;
		sample_nxt   = sample_q;
		busy_nxt     = busy_q;
		result_nxt   = result_q;
		done_nxt     = 1'b0;
		show_pins    = 1'b0;
		half_inc     = count_q + HALF_W'(1);
		if (in_data.command == CMD_START) begin
			if (!busy_q) begin
				cmd_word_nxt = {OP_PREFIX, in_data.phy_address, in_data.reg_address};
				sample_nxt   = '0;
				count_nxt    = '0;
				busy_nxt     = 1'b1;
			end else begin
				// repeat the last driven half, if any
				show_pins = (count_q != '0);
			end
		end else if (busy_q) begin
			show_pins = 1'b1;
			// sample during the low half of each read clock
			if (bit_idx >= CMD_END && !pin_clk) begin
				sample_nxt = {sample_q[SAMPLE_W-2:0], in_data.mdio_in};
			end
			if (half_inc >= TOTAL_HALVES) begin
				result_nxt = sample_nxt[DATA_W:1];
				busy_nxt   = 1'b0;
				count_nxt  = '0;
				done_nxt   = 1'b1;
			end else begin
				count_nxt = half_inc;
			end
		end

		res_nxt.mdc        = show_pins & pin_clk;
		res_nxt.mdio_out   = show_pins & pin_dout;
		res_nxt.mdio_drive = show_pins & pin_drv;
		res_nxt.busy_res   = busy_nxt;
		res_nxt.done_res   = done_nxt;
		res_nxt.read_data  = result_nxt;
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cmd_word_q <= '0;
			sample_q   <= '0;
			busy_q     <= 1'b0;
			result_q   <= '0;
		end else if (in_accept) begin
			count_q    <= count_nxt;
			cmd_word_q <= cmd_word_nxt;
			sample_q   <= sample_nxt;
			busy_q     <= busy_nxt;
			result_q   <= result_nxt;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data <= res_nxt;
		end
	end

	// Checks
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done result reports busy");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> out_valid && out_data.done_res)
		else $error("frame ended without a done result");

	a_drive_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mdio_drive |-> out_data.busy_res)
		else $error("data pin driven outside a frame");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < TOTAL_HALVES)
		else $error("half period count out of range");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> count_q == '0)
		else $error("half period count nonzero while idle");

endmodule
